### hdl/modular_exponentiation_macros.svh
// ----------------------------------------------------------------------------
// modular_exponentiation_macros.svh
// assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MX_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/modexp_pkg.sv
// ----------------------------------------------------------------------------
// modexp_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package modexp_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int DATA_BITS     = 32;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [31:0] MODULUS_RESET  = 32'd1000000007;
	localparam logic [31:0] EXPONENT_RESET = 32'd1000000005;

	localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT = 2'd1;

	// controller to datapath
	typedef struct packed {
		logic load;       // accept a base, start its reduction
		logic step;       // one shift-add step in both product units
		logic start_bit;  // start acc*sq and sq*sq for the current exponent bit
		logic take_sq;    // reduced base becomes the running square
		logic update;     // commit products, shift exponent
		logic deliver;    // move accumulator to the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic e_zero;     // no exponent bits left
		logic m_small;    // modulus below two
	} sts_t;

endpackage

`default_nettype wire

### hdl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// base^exponent mod modulus by right-to-left square-and-multiply
// ----------------------------------------------------------------------------
// channel   dir  width  contents
// s_axis    in   32     base_value
// m_axis    out  32     power_result
// cfg       in   2+32   register index, write data (modulus, exponent)
//
// one base at a time: the base is first reduced, then each exponent bit up
// to the highest set one is handled by two product units working side by
// side, one multiplier bit per cycle.
// a modulus below two gives 0.
// reset restores modulus 1000000007 and exponent 1000000005.
// a new base is taken while the previous result still waits on m_axis.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation #(
	parameter int WORD_BITS = modexp_pkg::WORD_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	input  wire logic [modexp_pkg::DATA_BITS-1:0]     s_axis_tdata,  // base_value
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	output logic      [modexp_pkg::DATA_BITS-1:0]     m_axis_tdata,  // power_result
	input  wire logic                                 cfg_wr_en,
	input  wire logic [modexp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [modexp_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	logic [WORD_BITS-1:0] modulus_q;
	logic [WORD_BITS-1:0] exponent_q;
	modexp_pkg::cmd_t     cmd;
	modexp_pkg::sts_t     sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= modexp_pkg::MODULUS_RESET[WORD_BITS-1:0];
			exponent_q <= modexp_pkg::EXPONENT_RESET[WORD_BITS-1:0];
		end else if (cfg_wr_en) begin
			if (cfg_index == modexp_pkg::REG_MODULUS) begin
				modulus_q <= cfg_data[WORD_BITS-1:0];
			end else if (cfg_index == modexp_pkg::REG_EXPONENT) begin
				exponent_q <= cfg_data[WORD_BITS-1:0];
			end
		end
	end

	modexp_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	modexp_dp #(.WORD_BITS(WORD_BITS)) u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.sts          (sts),
		.modulus      (modulus_q),
		.exponent     (exponent_q),
		.base_value   (s_axis_tdata),
		.power_result (m_axis_tdata)
	);

endmodule

`default_nettype wire

### hdl/modexp_mulmod.sv
// ----------------------------------------------------------------------------
// modexp_mulmod
// bit-serial modular product a*b mod m, one multiplier bit per step, msb first
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_mulmod #(
	parameter int WORD_BITS = modexp_pkg::WORD_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 start,
	input  wire logic                 step,
	input  wire logic [WORD_BITS-1:0] a,
	input  wire logic [WORD_BITS-1:0] b,
	input  wire logic [WORD_BITS-1:0] m,
	output logic      [WORD_BITS-1:0] r
);

	logic [WORD_BITS-1:0] r_q;
	logic [WORD_BITS-1:0] a_q;
	logic [WORD_BITS-1:0] b_q;
	logic [WORD_BITS:0]   m_ext;
	logic [WORD_BITS:0]   dbl;
	logic [WORD_BITS:0]   red1;
	logic [WORD_BITS:0]   sum;
	logic [WORD_BITS:0]   red2;

	// r stays below m, so 2r and r+a both stay below 2m
	always_comb begin
		m_ext = {1'b0, m};
		dbl   = {r_q, 1'b0};
		red1  = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
		sum   = red1 + (b_q[WORD_BITS-1] ? {1'b0, a_q} : '0);
		red2  = (sum >= m_ext) ? (sum - m_ext) : sum;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			a_q <= a;
			b_q <= b;
		end else if (step) begin
			r_q <= red2[WORD_BITS-1:0];
			b_q <= {b_q[WORD_BITS-2:0], 1'b0};
		end
	end

	assign r = r_q;

endmodule

`default_nettype wire

### hdl/modexp_dp.sv
// ----------------------------------------------------------------------------
// modexp_dp
// datapath: accumulator, running square, exponent shifter, two product units
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_dp #(
	parameter int WORD_BITS = modexp_pkg::WORD_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire modexp_pkg::cmd_t                 cmd,
	output modexp_pkg::sts_t                      sts,
	input  wire logic [WORD_BITS-1:0]             modulus,
	input  wire logic [WORD_BITS-1:0]             exponent,
	input  wire logic [modexp_pkg::DATA_BITS-1:0] base_value,
	output logic      [modexp_pkg::DATA_BITS-1:0] power_result
);

	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] sq_q;
	logic [WORD_BITS-1:0] e_q;
	logic [modexp_pkg::DATA_BITS-1:0] res_q;
	logic [WORD_BITS-1:0] sq_a;
	logic [WORD_BITS-1:0] sq_b;
	logic [WORD_BITS-1:0] acc_prod;
	logic [WORD_BITS-1:0] sq_prod;
	logic                 m_small;
	logic                 start_any;

	assign m_small   = (modulus[WORD_BITS-1:1] == '0);
	assign start_any = cmd.load | cmd.start_bit;

	// the square unit first reduces the base as 1*base mod m
	always_comb begin
		if (cmd.load) begin
			sq_a = WORD_BITS'(1);
			sq_b = base_value[WORD_BITS-1:0];
		end else begin
			sq_a = sq_q;
			sq_b = sq_q;
		end
	end

	modexp_mulmod #(.WORD_BITS(WORD_BITS)) u_mul_acc (
		.clk   (clk),
		.start (start_any),
		.step  (cmd.step),
		.a     (sq_q),
		.b     (acc_q),
		.m     (modulus),
		.r     (acc_prod)
	);

	modexp_mulmod #(.WORD_BITS(WORD_BITS)) u_mul_sq (
		.clk   (clk),
		.start (start_any),
		.step  (cmd.step),
		.a     (sq_a),
		.b     (sq_b),
		.m     (modulus),
		.r     (sq_prod)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			e_q   <= exponent;
			acc_q <= m_small ? '0 : WORD_BITS'(1);
		end
		if (cmd.take_sq) begin
			sq_q <= sq_prod;
		end
		if (cmd.update) begin
			if (e_q[0]) begin
				acc_q <= acc_prod;
			end
			sq_q <= sq_prod;
			e_q  <= {1'b0, e_q[WORD_BITS-1:1]};
		end
		if (cmd.deliver) begin
			res_q <= modexp_pkg::DATA_BITS'(acc_q);
		end
	end

	assign sts.e_zero  = (e_q == '0);
	assign sts.m_small = m_small;
	assign power_result = res_q;

endmodule

`default_nettype wire

### hdl/modexp_ctrl.sv
// ----------------------------------------------------------------------------
// modexp_ctrl
// sequencer for reduction, per-bit products and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_ctrl #(
	parameter int WORD_BITS = modexp_pkg::WORD_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output modexp_pkg::cmd_t      cmd,
	input  wire modexp_pkg::sts_t sts
);

	localparam int CNT_BITS = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED,
		ST_LOADSQ,
		ST_BIT,
		ST_MUL,
		ST_UPDATE,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                out_valid_q;
	logic                accept;
	logic                out_free;
	logic                out_load;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid & in_ready;
	assign out_free = ~out_valid_q | out_ready;
	assign out_load = (state_q == ST_DONE) && out_free;

	always_comb begin
		cmd           = '0;
		cmd.load      = accept;
		cmd.step      = (state_q == ST_RED) || (state_q == ST_MUL);
		cmd.take_sq   = (state_q == ST_LOADSQ);
		cmd.start_bit = (state_q == ST_BIT) && !sts.e_zero;
		cmd.update    = (state_q == ST_UPDATE);
		cmd.deliver   = out_load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= sts.m_small ? ST_DONE : ST_RED;
					end
				end
				ST_RED: begin
					if (cnt_q == CNT_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_LOADSQ;
					end else begin
						cnt_q <= cnt_q + CNT_BITS'(1);
					end
				end
				ST_LOADSQ: begin
					state_q <= ST_BIT;
				end
				ST_BIT: begin
					cnt_q   <= '0;
					state_q <= sts.e_zero ? ST_DONE : ST_MUL;
				end
				ST_MUL: begin
					if (cnt_q == CNT_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_UPDATE;
					end else begin
						cnt_q <= cnt_q + CNT_BITS'(1);
					end
				end
				ST_UPDATE: begin
					state_q <= ST_BIT;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### hdl/modexp_checker.sv
// ----------------------------------------------------------------------------
// modexp_checker
// port-level checks on the stream handshakes, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "modular_exponentiation_macros.svh"

module modexp_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_axis_tvalid,
	input wire logic                             s_axis_tready,
	input wire logic                             m_axis_tvalid,
	input wire logic                             m_axis_tready,
	input wire logic [modexp_pkg::DATA_BITS-1:0] m_axis_tdata
);

	// stalled result beat holds
	`MX_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result beat dropped while stalled")
	`MX_ASSERT_NEXT(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result data changed while stalled")
	// one base in flight: no second accept right after the first
	`MX_ASSERT_NEXT(a_one_busy, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while a base is in work")
	// a result never appears in the cycle after a base is taken
	`MX_ASSERT_NEXT(a_no_instant, clk, arst_n, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result came too early after accept")

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### dv/modular_exponentiation_tb.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_tb
// self-checking bench for the square-and-multiply power unit
// ----------------------------------------------------------------------------
// bases stream in on s_axis while a scoreboard predicts base^exponent mod
// modulus from its own copy of the two registers; every m_axis beat is checked
// in order. directed corner cases come first, then randomized batches under
// a range of register settings, sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

class power_scoreboard;
	bit [31:0] modulus;
	bit [31:0] exponent;
	bit [31:0] pending_powers[$];
	int        mismatches;

	function new();
		modulus    = modexp_pkg::MODULUS_RESET;
		exponent   = modexp_pkg::EXPONENT_RESET;
		mismatches = 0;
	endfunction

	function void write_register(bit [1:0] index, bit [31:0] value);
		if (index == modexp_pkg::REG_MODULUS) begin
			modulus = value;
		end else if (index == modexp_pkg::REG_EXPONENT) begin
			exponent = value;
		end
	endfunction

	function bit [31:0] expected_power(bit [31:0] base);
		bit [63:0] acc;
		bit [63:0] sq;
		bit [63:0] m;
		m = modulus;
		if (m < 2) return 32'd0;
		acc = 64'd1;
		sq  = base % m;
		for (int i = 0; i < 32; i++) begin
			if (exponent[i]) acc = (acc * sq) % m;
			sq = (sq * sq) % m;
		end
		return acc[31:0];
	endfunction

	function void note_base(bit [31:0] base);
		pending_powers.insert(pending_powers.size(), expected_power(base));
	endfunction

	function void check_result(bit [31:0] actual);
		bit [31:0] want;
		if (pending_powers.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected power_result beat: actual %h", actual);
			return;
		end
		want = pending_powers.pop_front();
		if (want !== actual) begin
			mismatches++;
			if (mismatches <= 10)
				$display("power_result mismatch: expected %h actual %h (mod %h exp %h)",
					want, actual, modulus, exponent);
		end
	endfunction

	function int failures();
		return mismatches + pending_powers.size();
	endfunction
endclass

module modular_exponentiation_tb;

	localparam int CLK_HALF      = 5;
	localparam int LONG_HOLD     = 1500;
	localparam int WATCHDOG_MAX  = 50000;
	localparam int END_SETTLE    = 40;
	localparam int RANDOM_PHASES = 22;
	localparam int PHASE_ITEMS   = 24;

	// indexes the block has no register for
	localparam logic [modexp_pkg::CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
	localparam logic [modexp_pkg::CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 s_axis_tvalid;
	logic                                 s_axis_tready;
	logic [modexp_pkg::DATA_BITS-1:0]     s_axis_tdata;   // base_value
	logic                                 m_axis_tvalid;
	logic                                 m_axis_tready;
	logic [modexp_pkg::DATA_BITS-1:0]     m_axis_tdata;   // power_result
	logic                                 cfg_wr_en;
	logic [modexp_pkg::CFG_IDX_BITS-1:0]  cfg_index;
	logic [modexp_pkg::CFG_DATA_BITS-1:0] cfg_data;

	power_scoreboard sb;
	bit [31:0]       cur_modulus;
	bit              hold_request;
	int              idle_cycles;

	modular_exponentiation uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// monitor: register writes, accepted bases and result beats
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en) sb.write_register(cfg_index, cfg_data);
			if (s_axis_tvalid && s_axis_tready) sb.note_base(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_MAX) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// receiver: stall style is redrawn at random, plus one long hold-off
	initial begin
		int style;
		int phase_cnt;
		m_axis_tready = 1'b0;
		style = 0;
		phase_cnt = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			phase_cnt++;
			if (phase_cnt >= 50) begin
				phase_cnt = 0;
				style = $urandom_range(0, 3);
			end
			case (style)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= (phase_cnt % 4 == 0);
				default: m_axis_tready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	task automatic send_base(input bit [31:0] base);
		s_axis_tdata  <= base;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_bases(input bit [31:0] list[$]);
		foreach (list[i]) send_base(list[i]);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic set_register(input logic [modexp_pkg::CFG_IDX_BITS-1:0] index,
		input bit [31:0] value);
		cfg_index <= index;
		cfg_data  <= value;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input bit [31:0] modulus, input bit [31:0] exponent);
		set_register(modexp_pkg::REG_MODULUS, modulus);
		set_register(modexp_pkg::REG_EXPONENT, exponent);
		cur_modulus = modulus;
	endtask

	task automatic wait_for_results();
		while (sb.pending_powers.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic bit [31:0] pick_base(bit [31:0] m);
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 15);
			1: return m - 1;
			2: return m;
			3: return m + 1;
			4: return m * $urandom_range(2, 4);
			5: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: return $urandom();
		endcase
	endfunction

	function automatic bit [31:0] pick_modulus();
		bit [31:0] m;
		case ($urandom_range(0, 9))
			0: m = modexp_pkg::MODULUS_RESET;
			1: m = $urandom_range(2, 255);
			2: m = 32'h8000_0000 | $urandom();
			3: m = 32'hFFFF_FFFF - $urandom_range(0, 8);
			4: m = $urandom_range(0, 1);
			default: begin
				m = $urandom();
				if (m < 2) m = 2;
			end
		endcase
		return m;
	endfunction

	function automatic bit [31:0] pick_exponent();
		int k;
		if ($urandom_range(0, 7) == 0) return 32'hFFFF_FFFF;
		k = $urandom_range(0, 32);
		if (k == 0) return 32'd0;
		if (k == 32) return $urandom() | 32'h8000_0000;
		return ($urandom() >> (32 - k)) | (32'd1 << (k - 1));
	endfunction

	// bursts of random length; gaps only when gappy is set
	task automatic run_batch(input int count, input bit gappy);
		int remaining;
		int burst;
		int gap;
		remaining = count;
		while (remaining > 0) begin
			burst = $urandom_range(1, 8);
			while (burst > 0 && remaining > 0) begin
				send_base(pick_base(cur_modulus));
				burst--;
				remaining--;
			end
			if (gappy && remaining > 0) begin
				gap = $urandom_range(0, 5);
				if (gap > 0) begin
					s_axis_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		s_axis_tvalid <= 1'b0;
	endtask

	initial begin
		bit [31:0] directed[$];
		sb            = new();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_wr_en     = 1'b0;
		cfg_index     = modexp_pkg::REG_MODULUS;
		cfg_data      = '0;
		hold_request  = 1'b0;
		cur_modulus   = modexp_pkg::MODULUS_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: Fermat inverses mod 1e9+7
		directed = '{32'd0, 32'd1, 32'd2, 32'hFFFF_FFFF, 32'd1000000007, 32'd1000000006,
			32'd1000000008, 32'h8000_0000};
		send_bases(directed);
		wait_for_results();

		// zero exponent gives the empty product
		configure(modexp_pkg::MODULUS_RESET, 32'd0);
		directed = '{32'd0, 32'd5};
		send_bases(directed);
		wait_for_results();

		// modulus of one: everything collapses to zero
		configure(32'd1, 32'd0);
		directed = '{32'd7, 32'hFFFF_FFFF};
		send_bases(directed);
		wait_for_results();

		// modulus of zero
		configure(32'd0, 32'd3);
		directed = '{32'd3};
		send_bases(directed);
		wait_for_results();

		// widest modulus and exponent
		configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		directed = '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd2};
		send_bases(directed);
		wait_for_results();

		configure(32'd2, 32'd1);
		directed = '{32'd3, 32'hFFFF_FFFF};
		send_bases(directed);
		wait_for_results();

		// writes to unused indexes must leave the registers alone
		configure(32'd97, 32'd5);
		set_register(REG_SPARE_A, 32'hDEAD_BEEF);
		set_register(REG_SPARE_B, 32'h0000_0001);
		directed = '{32'd10, 32'd96, 32'd1234567};
		send_bases(directed);
		wait_for_results();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			configure(pick_modulus(), pick_exponent());
			if (phase == 2) begin
				// receiver holds off while the sender keeps offering
				hold_request = 1'b1;
				run_batch(PHASE_ITEMS, 1'b0);
			end else begin
				run_batch(PHASE_ITEMS, (phase % 4) != 1);
			end
			wait_for_results();
		end

		repeat (END_SETTLE) @(posedge clk);
		if (sb.failures() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
